/* rtl/double_hash_table_assert.svh */
// Assertion macros for the double hash table checker
`ifndef DOUBLE_HASH_TABLE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ASSERT_SVH

// Implication in the same cycle, clocked on clk, off while in reset
`define DHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the following cycle
`define DHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dht_pkg.sv */
// Types and constants shared by the double hash table modules
package dht_pkg;

	localparam int KEY_W    = 31;
	localparam int VAL_W    = 32;
	localparam int SLOT_W   = 7;
	localparam int HOME_W   = 7;
	localparam int STEP_LSB = 6;
	localparam int STEP_W   = 6;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_ERASE  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	typedef struct packed {
		func_t              func;
		logic [KEY_W-1:0]   item_key;
		logic [VAL_W-1:0]   item_value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [VAL_W-1:0]   found_value;
	} rsp_t;

	typedef struct packed {
		logic               used;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
	} entry_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_WRITE,
		S_DONE
	} seq_state_t;

endpackage

/* rtl/dht_mem.sv */
// Slot store: one write port, one registered read port
module dht_mem #(
	parameter int SLOTS = 128,
	parameter int AW    = $clog2(SLOTS)
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output dht_pkg::entry_t rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  dht_pkg::entry_t wr_data
);
	import dht_pkg::*;

	entry_t mem_q [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/dht_seq.sv */
// Probe sequencer: clearing pass, pipelined probe reads, write-back and result hold
module dht_seq #(
	parameter int SLOTS = 128,
	parameter int AW    = $clog2(SLOTS)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  dht_pkg::req_t   req,
	output logic            res_valid,
	output dht_pkg::rsp_t   res,
	input  logic            res_take,
	output logic            rd_en,
	output logic [AW-1:0]   rd_addr,
	input  dht_pkg::entry_t rd_data,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output dht_pkg::entry_t wr_data
);
	import dht_pkg::*;

	localparam int          CW      = $clog2(SLOTS + 1);
	localparam logic [AW:0] SLOTS_X = (AW + 1)'(SLOTS);

	seq_state_t        state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic              iss_q;
	logic              chk_s1;
	logic [AW-1:0]     chk_pos_s1;
	logic              chk_last_s1;

	func_t             func_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;
	logic [AW-1:0]     step_q;
	logic [AW-1:0]     pos_q;
	logic [CW-1:0]     n_q;

	status_t           status_q;
	logic [AW-1:0]     slot_q;
	logic [VAL_W-1:0]  found_q;
	entry_t            wr_entry_q;

	logic              accept;
	logic              issue;
	logic              last_issue;
	logic [AW-1:0]     home;
	logic [AW-1:0]     step_in;
	logic [AW:0]       sum;
	logic [AW-1:0]     pos_nxt;
	logic              hit;
	logic              chk_hit;
	logic              chk_end;

	assign accept     = (state_q == S_IDLE) && req_valid;
	assign issue      = (state_q == S_PROBE) && iss_q;
	assign last_issue = (n_q == CW'(SLOTS));
	assign home       = AW'(req.item_key[HOME_W-1:0]);
	assign step_in    = AW'({req.item_key[STEP_LSB+STEP_W-1:STEP_LSB+1], 1'b1});

	// step never exceeds the table size, so one conditional subtract wraps it
	assign sum     = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_nxt = (sum >= SLOTS_X) ? AW'(sum - SLOTS_X) : AW'(sum);

	always_comb begin
		case (func_q)
			FUNC_INSERT: hit = !rd_data.used;
			default:     hit = rd_data.used && (rd_data.key == key_q);
		endcase
	end

	assign chk_hit = (state_q == S_PROBE) && chk_s1 && hit;
	assign chk_end = (state_q == S_PROBE) && chk_s1 && !hit && chk_last_s1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					case (req.func)
						FUNC_INSERT, FUNC_LOOKUP, FUNC_ERASE: state_d = S_PROBE;
						default:                              state_d = S_DONE;
					endcase
				end
			end
			S_PROBE: begin
				if (chk_hit) begin
					state_d = (func_q == FUNC_LOOKUP) ? S_DONE : S_WRITE;
				end else if (chk_end) begin
					state_d = S_DONE;
				end
			end
			S_WRITE: state_d = S_DONE;
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall = 1'b1;
		res_valid = 1'b0;
		rd_en     = issue;
		rd_addr   = pos_q;
		wr_en     = 1'b0;
		wr_addr   = slot_q;
		wr_data   = wr_entry_q;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_IDLE:  req_stall = 1'b0;
			S_PROBE: ;
			S_WRITE: wr_en = 1'b1;
			S_DONE:  res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res = '{status: status_q, slot: slot_q[SLOT_W-1:0], found_value: found_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			iss_q   <= 1'b0;
			chk_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= issue;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				iss_q <= 1'b1;
			end else if (issue && last_issue) begin
				iss_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			key_q   <= req.item_key;
			value_q <= req.item_value;
			step_q  <= step_in;
			pos_q   <= home;
			n_q     <= '0;
			// unused operation code answers at once
			status_q <= ST_MISSING;
			slot_q   <= '0;
			found_q  <= '0;
		end
		if (issue) begin
			pos_q       <= pos_nxt;
			n_q         <= n_q + 1'b1;
			chk_pos_s1  <= pos_q;
			chk_last_s1 <= last_issue;
		end
		if (chk_hit) begin
			status_q <= ST_DONE;
			slot_q   <= chk_pos_s1;
			found_q  <= (func_q == FUNC_LOOKUP) ? rd_data.value : '0;
			if (func_q == FUNC_INSERT) begin
				wr_entry_q <= '{used: 1'b1, key: key_q, value: value_q};
			end else begin
				wr_entry_q <= '{used: 1'b0, key: rd_data.key, value: rd_data.value};
			end
		end else if (chk_end) begin
			status_q <= (func_q == FUNC_INSERT) ? ST_FULL : ST_MISSING;
			slot_q   <= '0;
			found_q  <= '0;
		end
	end

endmodule

/* rtl/double_hash_table.sv */
// Double hash table top level: slot store, probe sequencer and result register
//
// Open-addressed table of SLOTS entries (key, value, used flag) held in one
// synchronous memory. The home slot is the key's low 7 bits and the probe step
// is key bits 11..6 with bit 0 set; insert takes the first empty slot, lookup
// and erase the first used slot with a matching key, over the home slot plus
// up to SLOTS further probes. After reset the block runs a clearing pass,
// one slot per cycle, with req_stall high. One transaction is worked at a
// time; probe reads are issued one per cycle and checked in the cycle after,
// as the memory read is registered. A hit ends the probing: a lookup is then
// ready, while insert and erase first write the slot back. A full table or a
// missing key is reported once every probe has missed, an unused operation
// code without probing. The result sits in an output register, so the next
// request is taken while it waits to be collected.
module double_hash_table #(
	parameter int SLOTS = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dht_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dht_pkg::rsp_t rsp
);
	import dht_pkg::*;

	localparam int AW = $clog2(SLOTS);

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          res_valid;
	rsp_t          res;
	logic          res_take;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	dht_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	dht_seq #(.SLOTS(SLOTS), .AW(AW)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/dht_check.sv */
// Port-level checker for the double hash table, bound to the top level
`include "double_hash_table_assert.svh"

module dht_check (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input dht_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input dht_pkg::rsp_t rsp
);
	import dht_pkg::*;

	`DHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")
	`DHT_ASSERT_NOW(a_fail_zero, rsp_valid && (rsp.status != ST_DONE), (rsp.slot == '0) && (rsp.found_value == '0), "failed result carries data")
	`DHT_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "request taken while another is in work")
	`DHT_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(req_stall), "result appeared without a transaction in work")

endmodule

bind double_hash_table dht_check u_dht_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

/* tb/tb_double_hash_table.sv */
// Self-checking testbench for the double hash table: random and directed transactions
`timescale 1ns / 1ps

module tb_double_hash_table;
	import dht_pkg::*;

	localparam int SLOTS = 128;
	localparam int RANDOM_ITEMS = 950;
	localparam int LIMIT_CYCLES = 800_000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// Shadow table predicting every response and queuing it until collected
	class dht_scoreboard;
		bit                 occupied [SLOTS];
		logic [KEY_W-1:0]   stored_key [SLOTS];
		logic [VAL_W-1:0]   stored_value [SLOTS];
		rsp_t               expected_rsp [$];
		int                 errors;

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
			errors++;
		endtask

		function int unsigned probe(logic [KEY_W-1:0] k, int unsigned n);
			int unsigned home;
			int unsigned step;
			home = k[HOME_W-1:0];
			step = k[STEP_LSB +: STEP_W] | 1;
			return (home + n * step) % SLOTS;
		endfunction

		// First empty slot, or first live slot holding k, along the probe sequence
		function bit locate(logic [KEY_W-1:0] k, bit want_empty, output int unsigned s);
			s = 0;
			for (int unsigned n = 0; n <= SLOTS; n++) begin
				s = probe(k, n);
				if (want_empty ? !occupied[s] : (occupied[s] && stored_key[s] == k))
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function rsp_t predict_rsp(req_t r);
			rsp_t e;
			int unsigned s;
			e.status = ST_MISSING;
			e.slot = '0;
			e.found_value = '0;
			case (r.func)
				FUNC_INSERT: begin
					if (locate(r.item_key, 1'b1, s)) begin
						occupied[s] = 1'b1;
						stored_key[s] = r.item_key;
						stored_value[s] = r.item_value;
						e.status = ST_DONE;
						e.slot = SLOT_W'(s);
					end else
						e.status = ST_FULL;
				end
				FUNC_LOOKUP: begin
					if (locate(r.item_key, 1'b0, s)) begin
						e.status = ST_DONE;
						e.slot = SLOT_W'(s);
						e.found_value = stored_value[s];
					end
				end
				FUNC_ERASE: begin
					if (locate(r.item_key, 1'b0, s)) begin
						occupied[s] = 1'b0;
						e.status = ST_DONE;
						e.slot = SLOT_W'(s);
					end
				end
				default: ;
			endcase
			return e;
		endfunction

		function void note_request(req_t r);
			expected_rsp.push_back(predict_rsp(r));
		endfunction

		task check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				report("response with nothing outstanding", got, '0);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.status !== want.status)
				report("status", got.status, want.status);
			if (got.slot !== want.slot)
				report("slot", got.slot, want.slot);
			if (got.found_value !== want.found_value)
				report("found_value", got.found_value, want.found_value);
		endtask

		function int occupancy();
			int c;
			c = 0;
			foreach (occupied[i])
				c += occupied[i];
			return c;
		endfunction

		function bit random_resident_key(output logic [KEY_W-1:0] k);
			int unsigned start;
			int unsigned s;
			start = $urandom_range(0, SLOTS - 1);
			k = '0;
			for (int i = 0; i < SLOTS; i++) begin
				s = (start + i) % SLOTS;
				if (occupied[s]) begin
					k = stored_key[s];
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction
	endclass

	logic  clk;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	dht_scoreboard sb = new();
	bit req_no_gaps;
	bit rsp_no_gaps;
	int sent;

	double_hash_table #(.SLOTS(SLOTS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("Some tests failed");
		$finish;
	end

	function automatic req_t mk_req(logic [1:0] f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		req_t r;
		r.func = func_t'(f);
		r.item_key = k;
		r.item_value = v;
		return r;
	endfunction

	// Keys crowded onto a few home slots and steps, so probe chains get long
	function automatic logic [KEY_W-1:0] make_key();
		logic [KEY_W-1:0] k;
		k = KEY_W'($urandom);
		if ($urandom_range(0, 2) != 0)
			k[11:0] = {4'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
		return k;
	endfunction

	// valid is only dropped when a gap is drawn, so back-to-back items keep it high
	task automatic send_request(input req_t r);
		int gap;
		gap = req_no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
		sent++;
	endtask

	task automatic random_request(int ins_pct, int era_pct);
		req_t r;
		logic [KEY_W-1:0] k;
		int pick;
		pick = $urandom_range(0, 99);
		r = mk_req(FUNC_INSERT, make_key(), $urandom);
		if (pick < 4)
			r.func = func_t'(FUNC_UNUSED);
		else if (pick < 4 + ins_pct) begin
			// occasional duplicate of a key already held
			if ($urandom_range(0, 3) == 0 && sb.random_resident_key(k))
				r.item_key = k;
		end else begin
			r.func = (pick < 4 + ins_pct + era_pct) ? FUNC_ERASE : FUNC_LOOKUP;
			if ($urandom_range(0, 4) != 0 && sb.random_resident_key(k))
				r.item_key = k;
		end
		if (sent % 50 == 0) begin
			req_no_gaps = ($urandom_range(0, 3) == 0);
			rsp_no_gaps = ($urandom_range(0, 3) == 0);
		end
		send_request(r);
	endtask

	// Response side: check every accepted transaction, then hold stall for a drawn spell
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				sb.check_response(rsp);
				hold = rsp_no_gaps ? 0 : $urandom_range(0, 8);
			end else if (hold > 0)
				hold--;
			rsp_stall <= (hold > 0);
		end
	end

	initial begin
		int stop_at;
		sent = 0;
		req_no_gaps = 1'b0;
		rsp_no_gaps = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unused code, key and value extremes, duplicates, erase then reuse
		send_request(mk_req(FUNC_LOOKUP, '0, '0));
		send_request(mk_req(FUNC_ERASE, '0, '0));
		send_request(mk_req(FUNC_UNUSED, '1, '1));
		send_request(mk_req(FUNC_INSERT, '0, '0));
		send_request(mk_req(FUNC_INSERT, '1, '1));
		send_request(mk_req(FUNC_INSERT, '0, '1));
		send_request(mk_req(FUNC_LOOKUP, '0, '1));
		send_request(mk_req(FUNC_ERASE, '0, '0));
		send_request(mk_req(FUNC_LOOKUP, '0, '0));
		send_request(mk_req(FUNC_LOOKUP, '1, '0));
		send_request(mk_req(FUNC_INSERT, 31'h80, 32'hA5A5_5A5A));
		send_request(mk_req(FUNC_LOOKUP, 31'h80, '0));
		send_request(mk_req(FUNC_ERASE, '1, '0));
		send_request(mk_req(FUNC_ERASE, '1, '0));
		send_request(mk_req(FUNC_UNUSED, 31'h80, 32'h1234_5678));
		send_request(mk_req(FUNC_LOOKUP, 31'h80, '0));

		stop_at = sent + RANDOM_ITEMS;
		while (sent < stop_at) begin
			// fill until full, hit the full table with inserts and misses, then mixed traffic, then erase down below 8 entries
			while (sb.occupancy() < SLOTS && sent < stop_at)
				random_request(80, 5);
			repeat (8)
				if (sent < stop_at)
					random_request(50, 0);
			repeat (150)
				if (sent < stop_at)
					random_request(35, 30);
			while (sb.occupancy() >= 8 && sent < stop_at)
				random_request(10, 70);
		end
		req_valid <= 1'b0;

		while (sb.expected_rsp.size() > 0)
			@(posedge clk);
		repeat (SLOTS + 16) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* double_hash_table.f */
+incdir+rtl
rtl/dht_pkg.sv
rtl/dht_mem.sv
rtl/dht_seq.sv
rtl/double_hash_table.sv
rtl/dht_check.sv
tb/tb_double_hash_table.sv
